// ===== src/compact_size_varint_decoder_top_macros.svh =====
// assertion macros shared by the compact size decoder modules
`ifndef COMPACT_SIZE_VARINT_DECODER_TOP_MACROS_SVH
`define COMPACT_SIZE_VARINT_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property checked at every rising edge outside reset
`define CSZV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked at every rising edge outside reset
`define CSZV_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`else
`define CSZV_ASSERT(label, clk, rst, prop, msg)
`define CSZV_ASSERT_IMPL(label, clk, rst, cond, prop, msg)
`endif

`endif

// ===== src/cszv_pkg.sv =====
// types and constants of the compact size varint decoder
`timescale 1ns / 1ps
`default_nettype none
package cszv_pkg;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_TRUNC  = 2'd1,
      STATUS_NONMIN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_SHORT   = 2'd0,
      KIND_PREFIX  = 2'd1,
      KIND_PAYLOAD = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      LEN_2 = 2'd0,
      LEN_4 = 2'd1,
      LEN_8 = 2'd2
   } len_type;

   localparam logic [7:0]  PREFIX_16 = 8'hfd;
   localparam logic [7:0]  PREFIX_32 = 8'hfe;
   localparam logic [63:0] MIN_LEN_2 = 64'h0000_0000_0000_00fd;
   localparam logic [63:0] MIN_LEN_4 = 64'h0000_0000_0001_0000;
   localparam logic [63:0] MIN_LEN_8 = 64'h0000_0001_0000_0000;

   // one classified byte handed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [2:0] position;
      len_type    len;
      logic       emit;
      logic       trunc;
      logic [3:0] consumed;
   } cmd_type;

   function automatic logic [3:0] len_bytes(input len_type len);
      logic [3:0] n;
      case (len)
         LEN_2:   n = 4'd2;
         LEN_4:   n = 4'd4;
         default: n = 4'd8;
      endcase
      return n;
   endfunction

   function automatic logic [63:0] len_min(input len_type len);
      logic [63:0] m;
      case (len)
         LEN_2:   m = MIN_LEN_2;
         LEN_4:   m = MIN_LEN_4;
         default: m = MIN_LEN_8;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== src/cszv_front.sv =====
// front end: tracks integer framing and classifies each accepted byte
`timescale 1ns / 1ps
`default_nettype none
module cszv_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             end_of_data,
   output cszv_pkg::cmd_type     cmd
);

   logic [3:0]        rem_ff, rem_in;
   cszv_pkg::len_type len_ff, len_in;
   logic [2:0]        pos_ff, pos_in;
   logic [3:0]        rem_next;
   cszv_pkg::len_type prefix_len;

   always_comb begin
      if (data_byte == cszv_pkg::PREFIX_16) begin
         prefix_len = cszv_pkg::LEN_2;
      end else if (data_byte == cszv_pkg::PREFIX_32) begin
         prefix_len = cszv_pkg::LEN_4;
      end else begin
         prefix_len = cszv_pkg::LEN_8;
      end
   end

   always_comb begin
      rem_next      = rem_ff - 4'd1;
      rem_in        = rem_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      cmd.data_byte = data_byte;
      cmd.position  = pos_ff;
      cmd.len       = len_ff;
      cmd.kind      = cszv_pkg::KIND_PAYLOAD;
      cmd.emit      = 1'b0;
      cmd.trunc     = 1'b0;
      cmd.consumed  = 4'd1 + cszv_pkg::len_bytes(len_ff) - rem_next;
      if (rem_ff == 4'd0) begin
         cmd.consumed = 4'd1;
         if (data_byte < cszv_pkg::PREFIX_16) begin
            cmd.kind = cszv_pkg::KIND_SHORT;
            cmd.emit = 1'b1;
         end else begin
            cmd.kind = cszv_pkg::KIND_PREFIX;
            cmd.len  = prefix_len;
            if (end_of_data) begin
               cmd.emit  = 1'b1;
               cmd.trunc = 1'b1;
            end else begin
               rem_in = cszv_pkg::len_bytes(prefix_len);
               len_in = prefix_len;
               pos_in = 3'd0;
            end
         end
      end else if (rem_next == 4'd0) begin
         cmd.emit = 1'b1;
         rem_in   = 4'd0;
      end else if (end_of_data) begin
         cmd.emit  = 1'b1;
         cmd.trunc = 1'b1;
         rem_in    = 4'd0;
      end else begin
         rem_in = rem_next;
         pos_in = pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 4'd0;
         len_ff <= cszv_pkg::LEN_2;
         pos_ff <= 3'd0;
      end else if (accept) begin
         rem_ff <= rem_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/cszv_queue.sv =====
// short queue of classified bytes between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "compact_size_varint_decoder_top_macros.svh"
module cszv_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire cszv_pkg::cmd_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output cszv_pkg::cmd_type      out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cszv_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   `CSZV_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `CSZV_ASSERT_IMPL(a_count_push, clock, reset, push && !pop, ##1 count_ff == $past(count_ff) + CNT_W'(1), "queue count missed a push")

endmodule
`default_nettype wire

// ===== src/cszv_back.sv =====
// back end: assembles payload bytes and holds the result register
`timescale 1ns / 1ps
`default_nettype none
`include "compact_size_varint_decoder_top_macros.svh"
module cszv_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire cszv_pkg::cmd_type cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [63:0]            rsp_decoded_value,
   output logic [3:0]             rsp_bytes_consumed,
   output logic [1:0]             rsp_status
);

   logic [63:0]          acc_ff, acc_in;
   logic                 valid_ff, valid_in;
   logic [63:0]          value_ff, value_in;
   logic [3:0]           consumed_ff, consumed_in;
   cszv_pkg::status_type status_ff, status_in;
   logic [63:0]          merged;
   logic                 take, load;

   // stall only when this beat makes a result and the output is still full
   assign cmd_ready = !cmd.emit || !valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign load      = take && cmd.emit;

   assign merged = acc_ff | ({56'd0, cmd.data_byte} << {cmd.position, 3'b000});

   always_comb begin
      acc_in      = acc_ff;
      value_in    = 64'd0;
      consumed_in = cmd.consumed;
      status_in   = cszv_pkg::STATUS_OK;
      if (take) begin
         case (cmd.kind)
            cszv_pkg::KIND_PREFIX:  acc_in = 64'd0;
            cszv_pkg::KIND_PAYLOAD: acc_in = cmd.emit ? 64'd0 : merged;
            default:                acc_in = acc_ff;
         endcase
      end
      case (cmd.kind)
         cszv_pkg::KIND_SHORT: begin
            value_in = {56'd0, cmd.data_byte};
         end
         cszv_pkg::KIND_PREFIX: begin
            status_in = cszv_pkg::STATUS_TRUNC;
         end
         default: begin
            if (cmd.trunc) begin
               status_in = cszv_pkg::STATUS_TRUNC;
            end else if (merged < cszv_pkg::len_min(cmd.len)) begin
               status_in = cszv_pkg::STATUS_NONMIN;
            end else begin
               value_in = merged;
            end
         end
      endcase
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 64'd0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff    <= value_in;
         consumed_ff <= consumed_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_decoded_value  = value_ff;
   assign rsp_bytes_consumed = consumed_ff;
   assign rsp_status         = status_ff;

   `CSZV_ASSERT_IMPL(a_zero_on_error, clock, reset, valid_ff && status_ff != cszv_pkg::STATUS_OK, value_ff == 64'd0, "error result carries a value")
   `CSZV_ASSERT_IMPL(a_consumed_range, clock, reset, valid_ff, consumed_ff >= 4'd1 && consumed_ff <= 4'd9, "bytes consumed out of range")

endmodule
`default_nettype wire

// ===== src/compact_size_varint_decoder_top.sv =====
// top level of the compact size varint decoder
// usage:
//   req channel carries one stream byte per beat with an end flag that marks the
//   last byte available; rsp channel carries one decoded integer per beat with
//   its value, the bytes it took and a status (ok, truncated, non-minimal).
//   a byte below 0xfd is a value on its own; 0xfd, 0xfe and 0xff are followed by
//   2, 4 or 8 little-endian payload bytes. bytes that finish nothing give no beat.
// timing:
//   one byte per cycle sustained while rsp_ready keeps up; the front classifier and the back
//   assembler each work one byte per cycle, joined by a QUEUE_DEPTH entry queue.
//   rsp_valid rises once the completing byte taken on req has passed the queue and
//   then the result register, which waits while an earlier result is still held.
// stalls:
//   when rsp_ready is low the result register holds; the back keeps taking
//   payload bytes that make no result, and req_ready drops only once the
//   queue is full.
// reset:
//   synchronous, active high; empties the queue and the result register and
//   returns the decoder to waiting for the first byte of an integer.
`timescale 1ns / 1ps
`default_nettype none
module compact_size_varint_decoder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_end_of_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [63:0]       rsp_decoded_value,
   output logic [3:0]        rsp_bytes_consumed,
   output logic [1:0]        rsp_status
);

   cszv_pkg::cmd_type front_cmd;
   cszv_pkg::cmd_type back_cmd;
   logic              back_valid;
   logic              back_ready;

   cszv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_valid && req_ready),
      .data_byte   (req_data_byte),
      .end_of_data (req_end_of_data),
      .cmd         (front_cmd)
   );

   cszv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_cmd)
   );

   cszv_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (back_valid),
      .cmd_ready          (back_ready),
      .cmd                (back_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_decoded_value  (rsp_decoded_value),
      .rsp_bytes_consumed (rsp_bytes_consumed),
      .rsp_status         (rsp_status)
   );

endmodule
`default_nettype wire

// ===== verif/compact_size_varint_decoder_top_test.sv =====
// testbench for the compact size varint decoder: random byte streams against a predictor
`timescale 1ns / 1ps
module compact_size_varint_decoder_top_test;

   localparam logic [7:0] PREFIX_64 = 8'hff;
   localparam int IDLE_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT = 20;

   typedef struct {
      logic [63:0]          value;
      logic [3:0]           consumed;
      cszv_pkg::status_type status;
   } varint_result_type;

   class varint_scoreboard;
      logic [3:0]        payload_left;
      logic [3:0]        payload_len;
      logic [2:0]        next_pos;
      logic [63:0]       assembled;
      varint_result_type pending_results[$];
      int bytes_in;
      int results_seen;
      int ok_seen;
      int trunc_seen;
      int nonmin_seen;
      int mismatches;

      function new();
         clear_integer();
         bytes_in = 0;
         results_seen = 0;
         ok_seen = 0;
         trunc_seen = 0;
         nonmin_seen = 0;
         mismatches = 0;
      endfunction

      function void clear_integer();
         payload_left = '0;
         payload_len = '0;
         next_pos = '0;
         assembled = '0;
      endfunction

      function void push_result(logic [63:0] value, logic [3:0] consumed,
                                cszv_pkg::status_type status);
         varint_result_type r;
         r.value = value;
         r.consumed = consumed;
         r.status = status;
         pending_results.push_back(r);
      endfunction

      // predicts the decoder for one accepted stream byte
      function void decode_byte(logic [7:0] b, logic last);
         logic [3:0]  consumed;
         logic [63:0] floor_value;
         bytes_in++;
         if (payload_left == 0) begin
            if (b < cszv_pkg::PREFIX_16) begin
               clear_integer();
               push_result({56'h0, b}, 4'd1, cszv_pkg::STATUS_OK);
               return;
            end
            payload_len = (b == cszv_pkg::PREFIX_16) ? 4'd2 :
                          (b == cszv_pkg::PREFIX_32) ? 4'd4 : 4'd8;
            payload_left = payload_len;
            next_pos = '0;
            assembled = '0;
            if (last) begin
               clear_integer();
               push_result('0, 4'd1, cszv_pkg::STATUS_TRUNC);
            end
            return;
         end
         assembled |= {56'h0, b} << (8 * next_pos);
         next_pos = next_pos + 3'd1;
         payload_left = payload_left - 4'd1;
         consumed = 4'd1 + payload_len - payload_left;
         if (payload_left == 0) begin
            case (payload_len)
               4'd2:    floor_value = cszv_pkg::MIN_LEN_2;
               4'd4:    floor_value = cszv_pkg::MIN_LEN_4;
               default: floor_value = cszv_pkg::MIN_LEN_8;
            endcase
            if (assembled < floor_value)
               push_result('0, consumed, cszv_pkg::STATUS_NONMIN);
            else
               push_result(assembled, consumed, cszv_pkg::STATUS_OK);
            clear_integer();
         end else if (last) begin
            clear_integer();
            push_result('0, consumed, cszv_pkg::STATUS_TRUNC);
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, what);
      endtask

      task check_result(logic [63:0] value, logic [3:0] consumed, logic [1:0] status);
         varint_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected, value %h", value));
            return;
         end
         want = pending_results.pop_front();
         case (want.status)
            cszv_pkg::STATUS_OK:    ok_seen++;
            cszv_pkg::STATUS_TRUNC: trunc_seen++;
            default:                nonmin_seen++;
         endcase
         if (value !== want.value)
            report_mismatch($sformatf("decoded_value %h, want %h", value, want.value));
         if (consumed !== want.consumed)
            report_mismatch($sformatf("bytes_consumed %0d, want %0d", consumed, want.consumed));
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %s", status, want.status.name()));
      endtask

      task check_drained();
         if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_decoded_value;
   logic [3:0]  rsp_bytes_consumed;
   logic [1:0]  rsp_status;

   varint_scoreboard sb;
   int burst_left = 0;
   int rsp_cycles = 0;
   int idle_cycles = 0;

   compact_size_varint_decoder_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_data    (req_end_of_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_decoded_value  (rsp_decoded_value),
      .rsp_bytes_consumed (rsp_bytes_consumed),
      .rsp_status         (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: stall behavior steps through four patterns as the run goes on
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_decoded_value, rsp_bytes_consumed, rsp_status);
         case ((rsp_cycles / 150) % 4)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= ((rsp_cycles % 9) < 4);
         endcase
         rsp_cycles++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat on either channel for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // sender works in bursts; valid stays high across back-to-back beats
   task send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_data <= last;
      do @(posedge clock); while (!req_ready);
      sb.decode_byte(b, last);
      burst_left--;
   endtask

   task wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task send_random_integer();
      int          pick;
      int          nbytes;
      int          cut;
      logic [7:0]  prefix;
      logic [63:0] floor_value;
      logic [63:0] top_value;
      logic [63:0] value;
      logic        ends_here;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end else if (pick < 28) begin
         send_byte(8'($urandom_range(0, 252)), ($urandom_range(0, 7) == 0));
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               nbytes = 2;
               prefix = cszv_pkg::PREFIX_16;
               floor_value = cszv_pkg::MIN_LEN_2;
               top_value = 64'h0000_0000_0000_ffff;
            end
            1: begin
               nbytes = 4;
               prefix = cszv_pkg::PREFIX_32;
               floor_value = cszv_pkg::MIN_LEN_4;
               top_value = 64'h0000_0000_ffff_ffff;
            end
            default: begin
               nbytes = 8;
               prefix = PREFIX_64;
               floor_value = cszv_pkg::MIN_LEN_8;
               top_value = '1;
            end
         endcase
         case ($urandom_range(0, 5))
            0:       value = floor_value;
            1:       value = floor_value - 64'd1;
            2:       value = top_value;
            3:       value = {$urandom, $urandom} % floor_value;
            default: value = {$urandom, $urandom} & top_value;
         endcase
         // cut past the last byte means the integer runs to completion
         cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, nbytes - 1) : nbytes + 1;
         for (int i = 0; i <= nbytes && i <= cut; i++) begin
            ends_here = (i == cut) || (i == nbytes && $urandom_range(0, 7) == 0);
            send_byte((i == 0) ? prefix : 8'(value >> (8 * (i - 1))), ends_here);
         end
      end
   endtask

   initial begin
      bit paused;
      sb = new();
      paused = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_end_of_data <= 1'b0;
      rsp_ready <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short value, largest short value with end flag, prefix cut by end flag
      send_byte(8'h00, 1'b0);
      send_byte(8'hfc, 1'b1);
      send_byte(cszv_pkg::PREFIX_16, 1'b1);
      // smallest 16-bit value, end flag on the completing byte
      send_byte(cszv_pkg::PREFIX_16, 1'b0);
      send_byte(8'hfd, 1'b0);
      send_byte(8'h00, 1'b1);
      // non-minimal 16-bit form
      send_byte(cszv_pkg::PREFIX_16, 1'b0);
      send_byte(8'hfc, 1'b0);
      send_byte(8'h00, 1'b0);
      // payload cut short
      send_byte(cszv_pkg::PREFIX_16, 1'b0);
      send_byte(8'h12, 1'b1);
      // smallest 32-bit value
      send_byte(cszv_pkg::PREFIX_32, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      // largest 64-bit value
      send_byte(PREFIX_64, 1'b0);
      repeat (8) send_byte(8'hff, 1'b0);
      wait_for_results();

      while (sb.bytes_in < 800) begin
         send_random_integer();
         if (!paused && sb.bytes_in >= 400) begin
            wait_for_results();
            paused = 1'b1;
         end
      end
      wait_for_results();
      sb.check_drained();

      $display("run covered %0d stream bytes and %0d decoded integers",
               sb.bytes_in, sb.results_seen);
      $display("by status: %0d ok, %0d truncated, %0d non-minimal",
               sb.ok_seen, sb.trunc_seen, sb.nonmin_seen);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
